/* rtl/core/ipv4_thp_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4_thp_pkg
// Types and constants shared by the IPv4 transport header parser.
// ----------------------------------------------------------------------------
package ipv4_thp_pkg;

    localparam int unsigned IDX_W = 17;

    localparam logic [IDX_W-1:0] IDX_MAX       = '1;
    localparam logic [IDX_W-1:0] MIN_HDR_BYTES = 17'd20;
    localparam logic [6:0]       UDP_HDR_BYTES = 7'd8;

    localparam logic [3:0] IP_VERSION4 = 4'd4;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;

    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_RUNT         = 4'd1;
    localparam logic [3:0] ST_VERSION      = 4'd2;
    localparam logic [3:0] ST_SHORT_IHL    = 4'd3;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd4;
    localparam logic [3:0] ST_SHORT_TCP    = 4'd5;
    localparam logic [3:0] ST_TCP_OFFSET   = 4'd6;
    localparam logic [3:0] ST_SHORT_UDP    = 4'd7;
    localparam logic [3:0] ST_UNSUPPORTED  = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  protocol_number;
        logic [31:0] src_ip_addr;
        logic [31:0] dst_ip_addr;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
        logic        fin_flag;
        logic [6:0]  payload_offset;
        logic [15:0] payload_length;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [3:0]       ip_header_words;
        logic [3:0]       ip_version;
        logic [15:0]      declared_length;
        logic [7:0]       protocol;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [3:0]       transport_words;
        logic             fin;
    } t_hdr_state;

endpackage

/* rtl/core/ipv4_thp_capture.sv */
// ----------------------------------------------------------------------------
// ipv4_thp_capture
// Per-packet header field capture and saturating byte counter.
// ----------------------------------------------------------------------------
module ipv4_thp_capture (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  ipv4_thp_pkg::t_in_item  i_item,
    output ipv4_thp_pkg::t_hdr_state o_next
);
    import ipv4_thp_pkg::*;

    t_hdr_state       r_st;
    t_hdr_state       n_st;
    logic [3:0]       w_ihl;
    logic [IDX_W-1:0] w_h;
    logic [IDX_W-1:0] w_idx;
    logic [7:0]       w_b;

    always_comb begin
        w_idx = r_st.byte_index;
        w_b   = i_item.data_byte;
        n_st  = r_st;
        w_ihl = (w_idx == '0) ? w_b[3:0] : r_st.ip_header_words;
        w_h   = {{(IDX_W-6){1'b0}}, w_ihl, 2'b00};

        if (w_idx == 17'd0) begin
            n_st.ip_version      = w_b[7:4];
            n_st.ip_header_words = w_b[3:0];
        end else if (w_idx == 17'd2) begin
            n_st.declared_length[15:8] = w_b;
        end else if (w_idx == 17'd3) begin
            n_st.declared_length[7:0] = w_b;
        end else if (w_idx == 17'd9) begin
            n_st.protocol = w_b;
        end else if (w_idx >= 17'd12 && w_idx <= 17'd15) begin
            case (w_idx[1:0])
                2'd0:    n_st.src_addr[31:24] = w_b;
                2'd1:    n_st.src_addr[23:16] = w_b;
                2'd2:    n_st.src_addr[15:8]  = w_b;
                default: n_st.src_addr[7:0]   = w_b;
            endcase
        end else if (w_idx >= 17'd16 && w_idx <= 17'd19) begin
            case (w_idx[1:0])
                2'd0:    n_st.dst_addr[31:24] = w_b;
                2'd1:    n_st.dst_addr[23:16] = w_b;
                2'd2:    n_st.dst_addr[15:8]  = w_b;
                default: n_st.dst_addr[7:0]   = w_b;
            endcase
        end

        // transport header fields relative to ihl*4
        if (w_idx == w_h) begin
            n_st.src_port[15:8] = w_b;
        end else if (w_idx == w_h + 17'd1) begin
            n_st.src_port[7:0] = w_b;
        end else if (w_idx == w_h + 17'd2) begin
            n_st.dst_port[15:8] = w_b;
        end else if (w_idx == w_h + 17'd3) begin
            n_st.dst_port[7:0] = w_b;
        end else if (w_idx == w_h + 17'd12) begin
            n_st.transport_words = w_b[7:4];
        end else if (w_idx == w_h + 17'd13) begin
            n_st.fin = w_b[0];
        end

        n_st.byte_index = (w_idx != IDX_MAX) ? w_idx + 17'd1 : w_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_adv && i_item.last_byte) begin
            r_st <= '0;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_next = n_st;

endmodule

/* rtl/core/ipv4_thp_check.sv */
// ----------------------------------------------------------------------------
// ipv4_thp_check
// End-of-packet checks and result field formation.
// ----------------------------------------------------------------------------
module ipv4_thp_check (
    input  ipv4_thp_pkg::t_hdr_state i_state,
    output ipv4_thp_pkg::t_out_item  o_result
);
    import ipv4_thp_pkg::*;

    logic [IDX_W-1:0] w_n;
    logic [5:0]       w_ihl_bytes;
    logic [6:0]       w_tcp_end;
    logic [6:0]       w_udp_end;
    logic [IDX_W-1:0] w_ihl_ext;
    logic [IDX_W-1:0] w_tcp_ext;
    logic [IDX_W-1:0] w_udp_ext;
    t_out_item        w_res;

    always_comb begin
        w_n         = i_state.byte_index;
        w_ihl_bytes = {i_state.ip_header_words, 2'b00};
        w_tcp_end   = {1'b0, w_ihl_bytes} + {1'b0, i_state.transport_words, 2'b00};
        w_udp_end   = {1'b0, w_ihl_bytes} + UDP_HDR_BYTES;
        w_ihl_ext   = {{(IDX_W-6){1'b0}}, w_ihl_bytes};
        w_tcp_ext   = {{(IDX_W-7){1'b0}}, w_tcp_end};
        w_udp_ext   = {{(IDX_W-7){1'b0}}, w_udp_end};

        w_res                 = '0;
        w_res.status          = ST_OK;
        w_res.protocol_number = i_state.protocol;
        w_res.src_ip_addr     = i_state.src_addr;
        w_res.dst_ip_addr     = i_state.dst_addr;

        if (w_n < MIN_HDR_BYTES) begin
            w_res.status = ST_RUNT;
        end else if (i_state.ip_version != IP_VERSION4) begin
            w_res.status = ST_VERSION;
        end else if (w_n < w_ihl_ext) begin
            w_res.status = ST_SHORT_IHL;
        end else if (w_n != {1'b0, i_state.declared_length}) begin
            w_res.status = ST_LEN_MISMATCH;
        end else if (i_state.protocol == PROTO_TCP) begin
            if (w_n < MIN_HDR_BYTES + w_ihl_ext) begin
                w_res.status = ST_SHORT_TCP;
            end else if (w_n < w_tcp_ext) begin
                w_res.status = ST_TCP_OFFSET;
            end else begin
                w_res.src_l4_port    = i_state.src_port;
                w_res.dst_l4_port    = i_state.dst_port;
                w_res.fin_flag       = i_state.fin;
                w_res.payload_offset = w_tcp_end;
                w_res.payload_length = 16'(w_n - w_tcp_ext);
            end
        end else if (i_state.protocol == PROTO_UDP) begin
            if (w_n < w_udp_ext) begin
                w_res.status = ST_SHORT_UDP;
            end else begin
                w_res.src_l4_port    = i_state.src_port;
                w_res.dst_l4_port    = i_state.dst_port;
                w_res.payload_offset = w_udp_end;
                w_res.payload_length = 16'(w_n - w_udp_ext);
            end
        end else begin
            w_res.status = ST_UNSUPPORTED;
        end
    end

    assign o_result = w_res;

endmodule

/* rtl/core/ipv4_transport_header_parser_top.sv */
// ----------------------------------------------------------------------------
// ipv4_transport_header_parser_top
// Result path: each accepted byte goes through the input reg; the result reg loads on a last byte.
// Throughput: one byte per cycle; a last byte waits only behind a stalled result.
// Reset: synchronous active low; clears valids and all captured header state.
// ----------------------------------------------------------------------------
module ipv4_transport_header_parser_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  ipv4_thp_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output ipv4_thp_pkg::t_out_item o_out_data
);
    import ipv4_thp_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       w_proc;
    logic       w_load;
    logic       w_out_free;
    t_hdr_state w_next;
    t_out_item  w_result;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && (!r_in.last_byte || w_out_free);
    assign w_load     = w_proc && r_in.last_byte;
    assign o_in_stall = r_in_valid && !w_proc;

    ipv4_thp_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_proc),
        .i_item  (r_in),
        .o_next  (w_next)
    );

    ipv4_thp_check u_check (
        .i_state  (w_next),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !w_load)
        else $error("result register overwritten while stalled");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in.last_byte && r_out_valid)
        else $error("input stalled without a pending last byte");

    a_error_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK |->
            r_out.src_l4_port == 16'd0 && r_out.dst_l4_port == 16'd0 &&
            !r_out.fin_flag && r_out.payload_offset == 7'd0 &&
            r_out.payload_length == 16'd0)
        else $error("transport fields nonzero on error transaction");
`endif

endmodule
